/* hw/rtl/erm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event rate meter package
// Shared widths, command and channel codes, request/result types.
// ----------------------------------------------------------------------------
package erm_pkg;

	localparam int COUNT_BITS = 20;                  // event counter width
	localparam int RATE_W     = 20;                  // published rate field width
	localparam int WIN_W      = 32;                  // window length register width
	localparam int TIME_W     = 64;                  // time and stamp width
	localparam int PROD_W     = COUNT_BITS + WIN_W;  // count * window
	localparam int STEP_W     = $clog2(PROD_W);      // divider step counter width
	localparam int NUM_SRC    = 3;
	localparam int NUM_CH     = 6;
	localparam int CH_W       = $clog2(NUM_CH);
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000 * 1000);

	// register decode: paddr[2] selects the word
	localparam logic REG_WINDOW = 1'b0;

	localparam logic [CH_W-1:0] CH_CTRL   = CH_W'(0);
	localparam logic [CH_W-1:0] CH_TOUCH  = CH_W'(1);
	localparam logic [CH_W-1:0] CH_MOTION = CH_W'(2);
	localparam logic [CH_W-1:0] CH_POLL   = CH_W'(3);
	localparam logic [CH_W-1:0] CH_FRESH  = CH_W'(4);
	localparam logic [CH_W-1:0] CH_STREAM = CH_W'(5);

	typedef enum logic [1:0] {
		CMD_CHECK  = 2'd0,
		CMD_POLL   = 2'd1,
		CMD_STREAM = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_LAUNCH,
		SQ_WAIT
	} seq_state_t;

	typedef enum logic {
		DV_IDLE,
		DV_ITER
	} div_state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [TIME_W-1:0] now_us;
		logic              ctrl_valid;
		logic [TIME_W-1:0] ctrl_stamp;
		logic              touch_valid;
		logic [TIME_W-1:0] touch_stamp;
		logic              motion_valid;
		logic [TIME_W-1:0] motion_stamp;
		logic [TIME_W-1:0] poll_stamp;
	} in_item_t;

	typedef struct packed {
		logic              window_closed;
		logic [RATE_W-1:0] ctrl_rate;
		logic [RATE_W-1:0] touch_rate;
		logic [RATE_W-1:0] motion_rate;
		logic [RATE_W-1:0] poll_rate;
		logic [RATE_W-1:0] fresh_rate;
		logic [RATE_W-1:0] stream_rate;
	} out_item_t;

	typedef struct packed {
		logic                  done;
		logic [COUNT_BITS-1:0] quot;
	} div_rsp_t;

endpackage : erm_pkg
`default_nettype wire

/* hw/rtl/erm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event rate meter request channel
// Valid/ready channel that carries one event or check request.
// ----------------------------------------------------------------------------
interface erm_in_if;
	import erm_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : erm_in_if
`default_nettype wire

/* hw/rtl/erm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event rate meter result channel
// Valid/ready channel that carries the published rates for each request.
// ----------------------------------------------------------------------------
interface erm_out_if;
	import erm_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface : erm_out_if
`default_nettype wire

/* hw/rtl/erm_apb.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event rate meter register port
// APB slave holding the window length register.
// ----------------------------------------------------------------------------
module erm_apb (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [erm_pkg::APB_AW-1:0] paddr,
	input  wire logic [erm_pkg::APB_DW-1:0] pwdata,
	output logic      [erm_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output logic      [erm_pkg::WIN_W-1:0]  window_length_us
);
	import erm_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (wr_en) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW: prdata = APB_DW'(window_q);
			default:    prdata = '0;
		endcase
	end

	assign window_length_us = window_q;

endmodule : erm_apb
`default_nettype wire

/* hw/rtl/erm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event rate meter scaling unit
// Shared unit: one multiply count*window on start, then a restoring divide
// by the elapsed time, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module erm_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [erm_pkg::COUNT_BITS-1:0] count,
	input  wire logic [erm_pkg::WIN_W-1:0]      win,
	input  wire logic [erm_pkg::TIME_W-1:0]     span,
	output logic                                busy,
	output erm_pkg::div_rsp_t                   rsp
);
	import erm_pkg::*;

	div_state_t            state_q, state_d;
	logic [STEP_W-1:0]     step_q;
	logic [PROD_W-1:0]     dvd_q;
	logic [TIME_W-1:0]     rem_q;
	logic [COUNT_BITS-1:0] quo_q;
	logic [PROD_W-1:0]     prod;
	logic [TIME_W:0]       shifted;
	logic [TIME_W+1:0]     diff;
	logic                  fits;
	logic                  last_step;

	assign prod      = PROD_W'(count) * PROD_W'(win);
	assign shifted   = {rem_q, dvd_q[PROD_W-1]};
	assign diff      = {1'b0, shifted} - {2'b00, span};
	assign fits      = ~diff[TIME_W+1];
	assign last_step = (step_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_ITER;
			DV_ITER: if (last_step) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q == DV_ITER);
		rsp.done = (state_q == DV_ITER) && last_step;
		rsp.quot = {quo_q[COUNT_BITS-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DV_IDLE && start) begin
				step_q <= STEP_W'(PROD_W - 1);
			end else if (state_q == DV_ITER && !last_step) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// quotient fits COUNT_BITS because span >= window; upper bits drop out
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			dvd_q <= prod;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == DV_ITER) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			rem_q <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
			quo_q <= rsp.quot;
		end
	end

endmodule : erm_div
`default_nettype wire

/* hw/rtl/multi_channel_event_rate_meter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Six-channel event rate meter
// Counts source updates, polls, fresh polls and stream events; on window
// close scales each count by window/elapsed and publishes the six rates.
// ----------------------------------------------------------------------------
// Timing: a request that does not close a window gives its result in the
//   cycle after acceptance. A closing check is scaled channel by channel by
//   the shared divider (a launch step with the multiply, 52 quotient steps each).
// Throughput: one request at a time; a new request may be taken while the
//   result of the previous one is being taken.
// Reset: asynchronous; clears all counters, stamps and rates, no sweep.
module multi_channel_event_rate_meter_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	erm_in_if.sink                          req,
	erm_out_if.source                       result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [erm_pkg::APB_AW-1:0] paddr,
	input  wire logic [erm_pkg::APB_DW-1:0] pwdata,
	output logic      [erm_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);
	import erm_pkg::*;

	seq_state_t            state_q, state_d;
	logic [CH_W-1:0]       idx_q;
	logic [COUNT_BITS-1:0] cnt_q [NUM_CH];
	logic [COUNT_BITS-1:0] pub_q [NUM_CH];
	logic [TIME_W-1:0]     last_src_q [NUM_SRC];
	logic [TIME_W-1:0]     last_poll_q;
	logic [TIME_W-1:0]     begin_q;
	logic                  started_q;
	logic [TIME_W-1:0]     span_q;
	logic                  out_valid_q;
	logic                  closed_q;

	logic [WIN_W-1:0]      window_length_us;
	logic [WIN_W-1:0]      win_eff;
	logic                  accept;
	logic                  is_check;
	logic [TIME_W-1:0]     begin_eff;
	logic [TIME_W-1:0]     span_w;
	logic                  close_w;
	logic                  src_valid [NUM_SRC];
	logic [TIME_W-1:0]     src_stamp [NUM_SRC];
	logic [NUM_SRC-1:0]    src_hit;
	logic                  fresh_w;
	logic                  div_start;
	logic                  div_busy;
	div_rsp_t              div_rsp;
	logic                  last_ch;
	logic                  cnt_all_zero;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

	erm_apb u_apb (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.window_length_us (window_length_us)
	);

	erm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.count  (cnt_q[idx_q]),
		.win    (win_eff),
		.span   (span_q),
		.busy   (div_busy),
		.rsp    (div_rsp)
	);

	// zero window behaves as one microsecond
	assign win_eff = (window_length_us == '0) ? WIN_W'(1) : window_length_us;

	assign src_valid[0] = req.data.ctrl_valid;
	assign src_valid[1] = req.data.touch_valid;
	assign src_valid[2] = req.data.motion_valid;
	assign src_stamp[0] = req.data.ctrl_stamp;
	assign src_stamp[1] = req.data.touch_stamp;
	assign src_stamp[2] = req.data.motion_stamp;

	always_comb begin
		for (int s = 0; s < NUM_SRC; s++) begin
			src_hit[s] = src_valid[s] && (src_stamp[s] != last_src_q[s]);
		end
	end

	assign is_check  = (req.data.command == CMD_CHECK);
	assign begin_eff = started_q ? begin_q : req.data.now_us;
	assign span_w    = req.data.now_us - begin_eff;
	assign close_w   = is_check && (span_w >= TIME_W'(win_eff));
	assign fresh_w   = (req.data.poll_stamp != last_poll_q);
	assign accept    = req.valid && req.ready;
	assign last_ch   = (idx_q == CH_STREAM);

	always_comb begin
		cnt_all_zero = 1'b1;
		for (int c = 0; c < NUM_CH; c++) begin
			if (cnt_q[c] != '0) cnt_all_zero = 1'b0;
		end
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE:   if (accept && close_w) state_d = SQ_LAUNCH;
			SQ_LAUNCH: state_d = SQ_WAIT;
			SQ_WAIT: begin
				if (div_rsp.done) state_d = last_ch ? SQ_IDLE : SQ_LAUNCH;
			end
			default:   state_d = SQ_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		req.ready = (state_q == SQ_IDLE) && (!out_valid_q || result.ready);
		div_start = (state_q == SQ_LAUNCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			last_poll_q <= '0;
			begin_q     <= '0;
			started_q   <= 1'b0;
			span_q      <= '0;
			out_valid_q <= 1'b0;
			closed_q    <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				cnt_q[c] <= '0;
				pub_q[c] <= '0;
			end
			for (int s = 0; s < NUM_SRC; s++) begin
				last_src_q[s] <= '0;
			end
		end else if (accept) begin
			out_valid_q <= !close_w;
			closed_q    <= 1'b0;
			idx_q       <= CH_CTRL;
			unique case (cmd_t'(req.data.command))
				CMD_CHECK: begin
					started_q <= 1'b1;
					span_q    <= span_w;
					if (!started_q || close_w) begin
						begin_q <= req.data.now_us;
					end
					for (int s = 0; s < NUM_SRC; s++) begin
						if (src_hit[s]) begin
							last_src_q[s] <= src_stamp[s];
							cnt_q[s]      <= sat_inc(cnt_q[s]);
						end
					end
				end
				CMD_POLL: begin
					cnt_q[CH_POLL] <= sat_inc(cnt_q[CH_POLL]);
					if (fresh_w) cnt_q[CH_FRESH] <= sat_inc(cnt_q[CH_FRESH]);
					last_poll_q <= req.data.poll_stamp;
				end
				CMD_STREAM: begin
					cnt_q[CH_STREAM] <= sat_inc(cnt_q[CH_STREAM]);
				end
				default: ;
			endcase
		end else if (state_q == SQ_WAIT && div_rsp.done) begin
			// publish this channel, clear its count, advance
			pub_q[idx_q] <= div_rsp.quot;
			cnt_q[idx_q] <= '0;
			if (last_ch) begin
				idx_q       <= CH_CTRL;
				out_valid_q <= 1'b1;
				closed_q    <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.data.window_closed = closed_q;
	assign result.data.ctrl_rate     = RATE_W'(pub_q[CH_CTRL]);
	assign result.data.touch_rate    = RATE_W'(pub_q[CH_TOUCH]);
	assign result.data.motion_rate   = RATE_W'(pub_q[CH_MOTION]);
	assign result.data.poll_rate     = RATE_W'(pub_q[CH_POLL]);
	assign result.data.fresh_rate    = RATE_W'(pub_q[CH_FRESH]);
	assign result.data.stream_rate   = RATE_W'(pub_q[CH_STREAM]);

	// a closing check hands off to the divider on the next cycle
	a_close_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept && close_w |=> state_q == SQ_LAUNCH)
		else $error("closing check did not start scaling");

	// no result may be shown while a division is in flight
	a_no_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !out_valid_q)
		else $error("result valid during division");

	// a published window leaves every counter cleared
	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && closed_q |-> cnt_all_zero && started_q)
		else $error("counters not cleared at window close");

	// the divider is only started from the launch step, and never while busy
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy && idx_q <= CH_STREAM)
		else $error("divider started while busy");

endmodule : multi_channel_event_rate_meter_top
`default_nettype wire
